FILE: rtl/hss_pkg.sv
// Shared types and constants for the Hermitian symmetric swap block.
// Holds the channel payload structs, opcodes, register indexes and status codes.
// No dependencies.
package hss_pkg;

    localparam int IDX_W      = 5;
    localparam int DATA_W     = 32;
    localparam int ELEM_W     = 2 * DATA_W;
    localparam int ORDER_W    = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    // Operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_SWAP  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_STORED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ORDER = 1'd1;

    localparam logic               UPPER_STORED_RESET = 1'b1;
    localparam logic [ORDER_W-1:0] MATRIX_ORDER_RESET = 6'd32;

    // Result status
    localparam logic ST_DONE  = 1'b0;
    localparam logic ST_ERROR = 1'b1;

    // Sign bit of the imaginary word: flip it to conjugate
    localparam logic [ELEM_W-1:0] CONJ_MASK = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0]        opcode;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value_re;
        logic [DATA_W-1:0] value_im;
        logic [IDX_W-1:0]  first_index;
        logic [IDX_W-1:0]  second_index;
    } hss_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_re;
        logic [DATA_W-1:0] read_im;
        logic              status;
    } hss_rsp_t;

    // Control from the top level to the swap step sequencer
    typedef struct packed {
        logic start;
        logic advance;
    } seq_cmd_t;

    // Description of the step the sequencer currently presents
    typedef struct packed {
        logic conj;
        logic single;
        logic done;
    } seq_flags_t;

endpackage

FILE: rtl/hss_ram.sv
// Generic simple RAM: one write port, two read ports with registered read data.
// Standalone; no package dependencies.
module hss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re_a,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic             re_b,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: rtl/hss_swap_seq.sv
// Step sequencer for the symmetric swap: walks the element pairs of one swap.
// Depends on hss_pkg.
module hss_swap_seq #(
    parameter int MAX_ORDER = 32,
    localparam int CW       = ($clog2(MAX_ORDER + 1) > 6) ? $clog2(MAX_ORDER + 1) : 6,
    localparam int DEPTH    = MAX_ORDER * MAX_ORDER,
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hss_pkg::seq_cmd_t        cmd,
    input  logic [hss_pkg::IDX_W-1:0] first_index,
    input  logic [hss_pkg::IDX_W-1:0] second_index,
    input  logic [CW-1:0]            order,
    input  logic                     upper,
    output logic [AW-1:0]            addr_a,
    output logic [AW-1:0]            addr_b,
    output hss_pkg::seq_flags_t      flags
);
    import hss_pkg::*;

    typedef enum logic [2:0] {
        P_PRE, P_DIAG, P_MID, P_CPL, P_POST, P_DONE
    } phase_t;

    phase_t phase_reg, phase_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] i1_reg, i2_reg, n_reg;
    logic          up_reg;
    logic [CW-1:0] k_inc;

    function automatic logic [AW-1:0] elem_addr(input logic [CW-1:0] r,
                                                input logic [CW-1:0] c);
        elem_addr = AW'(r) + AW'(c) * AW'(MAX_ORDER);
    endfunction

    assign k_inc = k_reg + CW'(1);

    // Advance to the next nonempty part of the walk
    always_comb
    begin
        phase_next = phase_reg;
        k_next     = k_reg;
        case (phase_reg)
            P_PRE:
            begin
                if (k_inc < i1_reg)
                begin
                    k_next = k_inc;
                end
                else
                begin
                    phase_next = P_DIAG;
                end
            end
            P_DIAG:
            begin
                if (i1_reg + CW'(1) < i2_reg)
                begin
                    phase_next = P_MID;
                    k_next     = i1_reg + CW'(1);
                end
                else
                begin
                    phase_next = P_CPL;
                end
            end
            P_MID:
            begin
                if (k_inc < i2_reg)
                begin
                    k_next = k_inc;
                end
                else
                begin
                    phase_next = P_CPL;
                end
            end
            P_CPL:
            begin
                if (i2_reg + CW'(1) < n_reg)
                begin
                    phase_next = P_POST;
                    k_next     = i2_reg + CW'(1);
                end
                else
                begin
                    phase_next = P_DONE;
                end
            end
            P_POST:
            begin
                if (k_inc < n_reg)
                begin
                    k_next = k_inc;
                end
                else
                begin
                    phase_next = P_DONE;
                end
            end
            default:
            begin
                phase_next = P_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_DONE;
            k_reg     <= '0;
        end
        else if (cmd.start)
        begin
            i1_reg <= CW'(first_index);
            i2_reg <= CW'(second_index);
            n_reg  <= order;
            up_reg <= upper;
            k_reg  <= '0;
            if (first_index != '0)
            begin
                phase_reg <= P_PRE;
            end
            else
            begin
                phase_reg <= P_DIAG;
            end
        end
        else if (cmd.advance)
        begin
            phase_reg <= phase_next;
            k_reg     <= k_next;
        end
    end

    // Element addresses of the current step
    always_comb
    begin
        addr_a       = elem_addr(i1_reg, i1_reg);
        addr_b       = elem_addr(i2_reg, i2_reg);
        flags.conj   = 1'b0;
        flags.single = 1'b0;
        flags.done   = 1'b0;
        case (phase_reg)
            P_PRE:
            begin
                addr_a = up_reg ? elem_addr(k_reg, i1_reg) : elem_addr(i1_reg, k_reg);
                addr_b = up_reg ? elem_addr(k_reg, i2_reg) : elem_addr(i2_reg, k_reg);
            end
            P_DIAG:
            begin
                addr_a = elem_addr(i1_reg, i1_reg);
                addr_b = elem_addr(i2_reg, i2_reg);
            end
            P_MID:
            begin
                addr_a     = up_reg ? elem_addr(i1_reg, k_reg) : elem_addr(k_reg, i1_reg);
                addr_b     = up_reg ? elem_addr(k_reg, i2_reg) : elem_addr(i2_reg, k_reg);
                flags.conj = 1'b1;
            end
            P_CPL:
            begin
                addr_a       = up_reg ? elem_addr(i1_reg, i2_reg) : elem_addr(i2_reg, i1_reg);
                flags.conj   = 1'b1;
                flags.single = 1'b1;
            end
            P_POST:
            begin
                addr_a = up_reg ? elem_addr(i1_reg, k_reg) : elem_addr(k_reg, i1_reg);
                addr_b = up_reg ? elem_addr(i2_reg, k_reg) : elem_addr(k_reg, i2_reg);
            end
            default:
            begin
                flags.done = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/hermitian_symmetric_swap.sv
// Hermitian symmetric row/column interchange block: top level.
// Depends on hss_pkg, hss_ram and hss_swap_seq.
//
// The block keeps one triangle of a Hermitian matrix of order up to MAX_ORDER in a
// single RAM (one write port, two registered read ports) and takes one command at a
// time: element write, element read, or symmetric swap of rows/columns first_index
// and second_index. A write or any rejected command passes straight to its result;
// a read first waits for the registered RAM data. A swap walks n-1 element pairs
// plus the coupling entry (n = effective order); each pair needs two writes through
// the single RAM write port, and the next pair's reads overlap the last write of
// the pair before unless they touch the entry being written. When first_index
// equals second_index the walk has n pairs and rereads the diagonal entry it just
// wrote only after that write, not alongside it. Results wait in an output
// register, and the next command is taken while an earlier result is still
// stalled. The RAM is not cleared; an entry that was never written reads as an
// arbitrary value.
module hermitian_symmetric_swap #(
    parameter int MAX_ORDER = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [hss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hss_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  hss_pkg::hss_cmd_t                 cmd,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output hss_pkg::hss_rsp_t                 rsp
);
    import hss_pkg::*;

    localparam int CW    = ($clog2(MAX_ORDER + 1) > 6) ? $clog2(MAX_ORDER + 1) : 6;
    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_RD_WAIT, S_SW_RD, S_SW_WA, S_SW_WB, S_FINISH
    } state_t;

    state_t state_reg;

    // Configuration
    logic               upper_reg;
    logic [ORDER_W-1:0] order_reg;

    // Swap step in flight
    logic [AW-1:0] a_reg, b_reg;
    logic          conj_reg, single_reg;

    // Result being built and output register
    logic              status_reg;
    logic [DATA_W-1:0] res_re_reg, res_im_reg;
    logic              rsp_valid_reg;
    hss_rsp_t          rsp_reg;

    // RAM ports
    logic              ram_we, ram_re_a, ram_re_b;
    logic [AW-1:0]     ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [ELEM_W-1:0] ram_wdata, rd_a, rd_b;

    // Sequencer
    seq_cmd_t      seq_cmd;
    seq_flags_t    seq_flags;
    logic [AW-1:0] step_a, step_b;

    logic          cmd_accept, rsp_load;
    logic [CW-1:0] n_eff;
    logic          elem_ok, swap_ok;
    logic [AW-1:0] elem_addr_w;
    logic [ELEM_W-1:0] conj_mask;
    logic          tail, hazard, issue;

    function automatic logic [AW-1:0] elem_addr(input logic [CW-1:0] r,
                                                input logic [CW-1:0] c);
        elem_addr = AW'(r) + AW'(c) * AW'(MAX_ORDER);
    endfunction

    // Accept one command at a time; the output register decouples the result side.
    assign cmd_stall  = (state_reg != S_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign rsp_load   = (state_reg == S_FINISH) && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // Orders above MAX_ORDER act as MAX_ORDER
    assign n_eff = (CW'(order_reg) > CW'(MAX_ORDER)) ? CW'(MAX_ORDER) : CW'(order_reg);

    assign elem_ok = (CW'(cmd.row) < CW'(MAX_ORDER)) && (CW'(cmd.col) < CW'(MAX_ORDER));
    assign swap_ok = (cmd.first_index <= cmd.second_index) &&
                     (CW'(cmd.second_index) < n_eff);
    assign elem_addr_w = elem_addr(CW'(cmd.row), CW'(cmd.col));

    assign conj_mask = conj_reg ? CONJ_MASK : '0;

    // RAM and sequencer control
    always_comb
    begin
        ram_we          = 1'b0;
        ram_waddr       = a_reg;
        ram_wdata       = '0;
        ram_re_a        = 1'b0;
        ram_re_b        = 1'b0;
        ram_raddr_a     = step_a;
        ram_raddr_b     = step_b;
        seq_cmd.start   = 1'b0;
        seq_cmd.advance = 1'b0;
        tail            = 1'b0;
        issue           = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    case (cmd.opcode)
                        OP_WRITE:
                        begin
                            ram_we    = elem_ok;
                            ram_waddr = elem_addr_w;
                            ram_wdata = {cmd.value_im, cmd.value_re};
                        end
                        OP_READ:
                        begin
                            ram_re_a    = elem_ok;
                            ram_raddr_a = elem_addr_w;
                        end
                        OP_SWAP:
                        begin
                            seq_cmd.start = swap_ok;
                        end
                        default:
                        begin
                            ram_we = 1'b0;
                        end
                    endcase
                end
            end
            S_SW_RD:
            begin
                issue = 1'b1;
            end
            S_SW_WA:
            begin
                // Write the first entry of the pair, or the lone coupling entry
                ram_we    = 1'b1;
                ram_waddr = a_reg;
                ram_wdata = (single_reg ? rd_a : rd_b) ^ conj_mask;
                tail      = single_reg;
            end
            S_SW_WB:
            begin
                ram_we    = 1'b1;
                ram_waddr = b_reg;
                ram_wdata = rd_a ^ conj_mask;
                tail      = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase

        // Overlap the next step's reads with the last write of this one, unless
        // the next step touches the entry being written right now.
        hazard = (step_a == ram_waddr) || (!seq_flags.single && (step_b == ram_waddr));
        if (tail && !seq_flags.done && !hazard)
        begin
            issue = 1'b1;
        end
        if (issue)
        begin
            ram_re_a        = 1'b1;
            ram_re_b        = !seq_flags.single;
            ram_raddr_a     = step_a;
            ram_raddr_b     = step_b;
            seq_cmd.advance = 1'b1;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= UPPER_STORED_RESET;
            order_reg <= MATRIX_ORDER_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_UPPER_STORED: upper_reg <= cfg_data[0];
                REG_MATRIX_ORDER: order_reg <= ORDER_W'(cfg_data);
                default:          upper_reg <= upper_reg;
            endcase
        end
    end

    // Command sequencing and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                a_reg      <= step_a;
                b_reg      <= step_b;
                conj_reg   <= seq_flags.conj;
                single_reg <= seq_flags.single;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_accept)
                    begin
                        res_re_reg <= '0;
                        res_im_reg <= '0;
                        status_reg <= ST_ERROR;
                        state_reg  <= S_FINISH;
                        case (cmd.opcode)
                            OP_WRITE:
                            begin
                                if (elem_ok)
                                begin
                                    status_reg <= ST_DONE;
                                end
                            end
                            OP_READ:
                            begin
                                if (elem_ok)
                                begin
                                    status_reg <= ST_DONE;
                                    state_reg  <= S_RD_WAIT;
                                end
                            end
                            OP_SWAP:
                            begin
                                if (swap_ok)
                                begin
                                    status_reg <= ST_DONE;
                                    state_reg  <= S_SW_RD;
                                end
                            end
                            default:
                            begin
                                status_reg <= ST_ERROR;
                            end
                        endcase
                    end
                end
                S_RD_WAIT:
                begin
                    res_re_reg <= rd_a[DATA_W-1:0];
                    res_im_reg <= rd_a[ELEM_W-1:DATA_W];
                    state_reg  <= S_FINISH;
                end
                S_SW_RD:
                begin
                    state_reg <= S_SW_WA;
                end
                S_SW_WA, S_SW_WB:
                begin
                    if (!tail)
                    begin
                        state_reg <= S_SW_WB;
                    end
                    else if (seq_flags.done)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else if (issue)
                    begin
                        state_reg <= S_SW_WA;
                    end
                    else
                    begin
                        state_reg <= S_SW_RD;
                    end
                end
                S_FINISH:
                begin
                    if (rsp_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Hold the result until the transfer, then load the next one
            if (rsp_load)
            begin
                rsp_valid_reg   <= 1'b1;
                rsp_reg.read_re <= res_re_reg;
                rsp_reg.read_im <= res_im_reg;
                rsp_reg.status  <= status_reg;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    hss_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re_a    (ram_re_a),
        .raddr_a (ram_raddr_a),
        .rdata_a (rd_a),
        .re_b    (ram_re_b),
        .raddr_b (ram_raddr_b),
        .rdata_b (rd_b)
    );

    hss_swap_seq #(
        .MAX_ORDER (MAX_ORDER)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (seq_cmd),
        .first_index  (cmd.first_index),
        .second_index (cmd.second_index),
        .order        (n_eff),
        .upper        (upper_reg),
        .addr_a       (step_a),
        .addr_b       (step_b),
        .flags        (seq_flags)
    );

    // A read never hits the entry written in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ((ram_re_a && (ram_raddr_a == ram_waddr)) ||
                     (ram_re_b && (ram_raddr_b == ram_waddr)))))
        else $error("read and write of the same RAM entry in one cycle");

    // First write of a step always follows the read issue of that step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SW_WA) |-> $past(issue))
        else $error("swap write without preceding read");

    // Sequencer still has a step whenever a fresh read is due
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SW_RD) |-> !seq_flags.done)
        else $error("swap read requested after walk finished");

    // The coupling entry is written once, never through the second write
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SW_WB) |-> !single_reg && ($past(state_reg) == S_SW_WA))
        else $error("second write of a single-entry step");

endmodule
